>>> src/rsws_pkg.sv
`default_nettype none

package rsws_pkg;

   localparam int IdW   = 16;
   localparam int DimW  = 13;
   localparam int KindW = 3;
   localparam int OpW   = 3;
   localparam int ModeW = 2;
   localparam int StatW = 2;
   localparam int CntW  = 7;

   typedef logic [CntW-1:0]  cnt_type;
   typedef logic [OpW-1:0]   op_code_type;
   typedef logic [ModeW-1:0] mode_type;
   typedef logic [StatW-1:0] stat_type;

   localparam op_code_type OP_PUSH  = 3'd0;
   localparam op_code_type OP_POP   = 3'd1;
   localparam op_code_type OP_PEEK  = 3'd2;
   localparam op_code_type OP_CLEAR = 3'd3;
   localparam op_code_type OP_FIND  = 3'd4;
   localparam op_code_type OP_COUNT = 3'd5;

   localparam mode_type KEY_ID   = 2'd0;
   localparam mode_type KEY_RES  = 2'd1;
   localparam mode_type KEY_KIND = 2'd2;

   localparam stat_type STAT_OK    = 2'd0;
   localparam stat_type STAT_EMPTY = 2'd1;
   localparam stat_type STAT_FULL  = 2'd2;

   typedef struct packed {
      logic [IdW-1:0]   id;
      logic [DimW-1:0]  width;
      logic [DimW-1:0]  height;
      logic [KindW-1:0] kind;
   } rec_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic exec;
      logic scan_step;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic search_go;
      logic scan_done;
      logic out_free;
   } sts_type;

   function automatic logic rec_match(rec_type e, mode_type mode, rec_type key);
      logic m;
      case (mode)
         KEY_ID:   m = (e.id == key.id);
         KEY_RES:  m = (e.width == key.width) && (e.height == key.height);
         KEY_KIND: m = (e.kind == key.kind);
         default:  m = 1'b0;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

>>> src/record_stack_with_search_top.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  op, key_mode, rec_id/width/height/kind
// rsp_      out        rsp_valid/rsp_ready  status, found, position, match_count,
//                                           top_id/width/height/kind, fill_now
//
// Push, pop, peek, clear: after acceptance the execute and finish states load the result;
// the next transaction is taken only once the block is back in idle.
// Find-first and count add a scan state that compares entries up to the fill level
// (at most DEPTH); the scan reads one entry a cycle from the single memory read port.
// Find-first ends at the first match from the top.
// Reset clears the fill level and the control state; the entry memory is not cleared.
// A new transaction is taken while a result waits; the block stalls in finish
// only while the output register still holds an untaken result.

module record_stack_with_search_top #(
   parameter int DEPTH = 64
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_ready,
   input  wire  [rsws_pkg::OpW-1:0]        req_op,
   input  wire  [rsws_pkg::ModeW-1:0]      req_key_mode,
   input  wire  [rsws_pkg::IdW-1:0]        req_rec_id,
   input  wire  [rsws_pkg::DimW-1:0]       req_rec_width,
   input  wire  [rsws_pkg::DimW-1:0]       req_rec_height,
   input  wire  [rsws_pkg::KindW-1:0]      req_rec_kind,
   output logic                            rsp_valid,
   input  wire                             rsp_ready,
   output logic [rsws_pkg::StatW-1:0]      rsp_status,
   output logic                            rsp_found,
   output logic [rsws_pkg::CntW-1:0]       rsp_position,
   output logic [rsws_pkg::CntW-1:0]       rsp_match_count,
   output logic [rsws_pkg::IdW-1:0]        rsp_top_id,
   output logic [rsws_pkg::DimW-1:0]       rsp_top_width,
   output logic [rsws_pkg::DimW-1:0]       rsp_top_height,
   output logic [rsws_pkg::KindW-1:0]      rsp_top_kind,
   output logic [rsws_pkg::CntW-1:0]       rsp_fill_now
);

   rsws_pkg::cmd_type cmd;
   rsws_pkg::sts_type sts;

   rsws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rsws_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_op          (req_op),
      .req_key_mode    (req_key_mode),
      .req_rec_id      (req_rec_id),
      .req_rec_width   (req_rec_width),
      .req_rec_height  (req_rec_height),
      .req_rec_kind    (req_rec_kind),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position),
      .rsp_match_count (rsp_match_count),
      .rsp_top_id      (rsp_top_id),
      .rsp_top_width   (rsp_top_width),
      .rsp_top_height  (rsp_top_height),
      .rsp_top_kind    (rsp_top_kind),
      .rsp_fill_now    (rsp_fill_now)
   );

endmodule

`default_nettype wire

>>> src/rsws_ctrl.sv
`default_nettype none

module rsws_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  rsws_pkg::sts_type    sts,
   output rsws_pkg::cmd_type    cmd
);

   rsws_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rsws_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rsws_pkg::S_IDLE: begin
            if (req_valid) state_in = rsws_pkg::S_EXEC;
         end
         rsws_pkg::S_EXEC: begin
            state_in = sts.search_go ? rsws_pkg::S_SCAN : rsws_pkg::S_FINISH;
         end
         rsws_pkg::S_SCAN: begin
            if (sts.scan_done) state_in = rsws_pkg::S_FINISH;
         end
         rsws_pkg::S_FINISH: begin
            // hold until the output register is free
            if (sts.out_free) state_in = rsws_pkg::S_IDLE;
         end
         default: state_in = rsws_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = (state_ff == rsws_pkg::S_IDLE);
      cmd.accept    = (state_ff == rsws_pkg::S_IDLE) && req_valid;
      cmd.exec      = (state_ff == rsws_pkg::S_EXEC);
      cmd.scan_step = (state_ff == rsws_pkg::S_SCAN);
      cmd.load_rsp  = (state_ff == rsws_pkg::S_FINISH) && sts.out_free;
   end

endmodule

`default_nettype wire

>>> src/rsws_dpath.sv
`default_nettype none

module rsws_dpath #(
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int FW = $clog2(DEPTH + 1)
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  rsws_pkg::cmd_type                    cmd,
   output rsws_pkg::sts_type                    sts,
   input  wire  [rsws_pkg::OpW-1:0]             req_op,
   input  wire  [rsws_pkg::ModeW-1:0]           req_key_mode,
   input  wire  [rsws_pkg::IdW-1:0]             req_rec_id,
   input  wire  [rsws_pkg::DimW-1:0]            req_rec_width,
   input  wire  [rsws_pkg::DimW-1:0]            req_rec_height,
   input  wire  [rsws_pkg::KindW-1:0]           req_rec_kind,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic [rsws_pkg::StatW-1:0]           rsp_status,
   output logic                                 rsp_found,
   output logic [rsws_pkg::CntW-1:0]            rsp_position,
   output logic [rsws_pkg::CntW-1:0]            rsp_match_count,
   output logic [rsws_pkg::IdW-1:0]             rsp_top_id,
   output logic [rsws_pkg::DimW-1:0]            rsp_top_width,
   output logic [rsws_pkg::DimW-1:0]            rsp_top_height,
   output logic [rsws_pkg::KindW-1:0]           rsp_top_kind,
   output logic [rsws_pkg::CntW-1:0]            rsp_fill_now
);

   rsws_pkg::rec_type     mem [DEPTH];
   rsws_pkg::rec_type     rd_data_ff;
   rsws_pkg::rec_type     key_ff;
   rsws_pkg::op_code_type op_ff;
   rsws_pkg::mode_type    mode_ff;
   rsws_pkg::stat_type    status_ff, status_in;
   logic [FW-1:0]         fill_ff, fill_in;
   logic [AW-1:0]         ptr_ff, left_ff, top_idx, rd_addr;
   logic [FW-1:0]         pos_ff, cnt_ff, first_ff;
   logic                  hit_ff;
   logic                  wr_en, rd_en, match, full, empty, is_search;

   logic                  rsp_valid_ff;
   rsws_pkg::stat_type    rsp_status_ff;
   logic                  rsp_found_ff;
   rsws_pkg::cnt_type     rsp_pos_ff, rsp_cnt_ff, rsp_fill_ff;
   rsws_pkg::rec_type     rsp_top_ff;

   assign full      = (fill_ff == FW'(DEPTH));
   assign empty     = (fill_ff == '0);
   assign top_idx   = AW'(fill_ff - FW'(1));
   assign is_search = (op_ff == rsws_pkg::OP_FIND) || (op_ff == rsws_pkg::OP_COUNT);
   assign match     = rsws_pkg::rec_match(rd_data_ff, mode_ff, key_ff);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff         <= req_op;
         mode_ff       <= req_key_mode;
         key_ff.id     <= req_rec_id;
         key_ff.width  <= req_rec_width;
         key_ff.height <= req_rec_height;
         key_ff.kind   <= req_rec_kind;
      end
   end

   always_comb begin
      fill_in   = fill_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      if (cmd.exec) begin
         status_in = rsws_pkg::STAT_OK;
         case (op_ff)
            rsws_pkg::OP_PUSH: begin
               if (full) begin
                  status_in = rsws_pkg::STAT_FULL;
               end else begin
                  wr_en   = 1'b1;
                  fill_in = fill_ff + FW'(1);
               end
            end
            rsws_pkg::OP_POP: begin
               if (empty) status_in = rsws_pkg::STAT_EMPTY;
               else       fill_in   = fill_ff - FW'(1);
            end
            rsws_pkg::OP_PEEK: begin
               if (empty) status_in = rsws_pkg::STAT_EMPTY;
            end
            rsws_pkg::OP_CLEAR: fill_in = '0;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
   end

   // exec reads the top entry: peek data, or the first entry of a scan
   assign rd_en   = cmd.exec || cmd.scan_step;
   assign rd_addr = cmd.exec ? top_idx : ptr_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[fill_ff[AW-1:0]] <= key_ff;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         ptr_ff  <= top_idx - AW'(1);
         left_ff <= top_idx;
         pos_ff  <= FW'(1);
         cnt_ff  <= '0;
         hit_ff  <= 1'b0;
      end else if (cmd.scan_step) begin
         if (match) begin
            cnt_ff <= cnt_ff + FW'(1);
            if (!hit_ff) begin
               hit_ff   <= 1'b1;
               first_ff <= pos_ff;
            end
         end
         ptr_ff  <= ptr_ff - AW'(1);
         left_ff <= left_ff - AW'(1);
         pos_ff  <= pos_ff + FW'(1);
      end
   end

   assign sts.search_go = is_search && !empty;
   assign sts.scan_done = (left_ff == '0) || (match && (op_ff == rsws_pkg::OP_FIND));
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_found_ff  <= is_search && hit_ff;
         rsp_pos_ff    <= ((op_ff == rsws_pkg::OP_FIND) && hit_ff) ?
                          rsws_pkg::cnt_type'(first_ff) : '0;
         rsp_cnt_ff    <= ((op_ff == rsws_pkg::OP_COUNT) && hit_ff) ?
                          rsws_pkg::cnt_type'(cnt_ff) : '0;
         rsp_top_ff    <= ((op_ff == rsws_pkg::OP_PEEK) &&
                           (status_ff == rsws_pkg::STAT_OK)) ? rd_data_ff : '0;
         rsp_fill_ff   <= rsws_pkg::cnt_type'(fill_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_position    = rsp_pos_ff;
   assign rsp_match_count = rsp_cnt_ff;
   assign rsp_top_id      = rsp_top_ff.id;
   assign rsp_top_width   = rsp_top_ff.width;
   assign rsp_top_height  = rsp_top_ff.height;
   assign rsp_top_kind    = rsp_top_ff.kind;
   assign rsp_fill_now    = rsp_fill_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(DEPTH))
      else $error("fill level above depth");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending result overwritten");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && (op_ff == rsws_pkg::OP_PUSH) && !full) |=>
      (fill_ff == $past(fill_ff) + FW'(1)))
      else $error("push did not advance fill level");

   a_search_keeps_fill: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |=> $stable(fill_ff))
      else $error("fill level moved during scan");

endmodule

`default_nettype wire

>>> dv/tb.sv
`default_nettype none

module tb;

   localparam int DEPTH       = 64;
   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_AT     = 80;
   localparam int HOLD_LEN    = 300;
   localparam int DRAIN_WAIT  = 80;

   localparam rsws_pkg::op_code_type OP_BAD6  = 3'd6;
   localparam rsws_pkg::op_code_type OP_BAD7  = 3'd7;
   localparam rsws_pkg::mode_type    KEY_NONE = 2'd3;

   typedef logic [rsws_pkg::IdW-1:0]   id_type;
   typedef logic [rsws_pkg::DimW-1:0]  dim_type;
   typedef logic [rsws_pkg::KindW-1:0] kind_type;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SEND,
      IDLE_RECV,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      rsws_pkg::op_code_type op;
      rsws_pkg::mode_type    mode;
      rsws_pkg::rec_type     rec;
   } req_item_type;

   typedef struct packed {
      rsws_pkg::stat_type status;
      logic               found;
      rsws_pkg::cnt_type  position;
      rsws_pkg::cnt_type  match_count;
      rsws_pkg::rec_type  top;
      rsws_pkg::cnt_type  fill_now;
   } stack_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           req_valid      = 1'b0;
   logic                           req_ready;
   logic [rsws_pkg::OpW-1:0]       req_op         = '0;
   logic [rsws_pkg::ModeW-1:0]     req_key_mode   = '0;
   logic [rsws_pkg::IdW-1:0]       req_rec_id     = '0;
   logic [rsws_pkg::DimW-1:0]      req_rec_width  = '0;
   logic [rsws_pkg::DimW-1:0]      req_rec_height = '0;
   logic [rsws_pkg::KindW-1:0]     req_rec_kind   = '0;
   logic                           rsp_valid;
   logic                           rsp_ready      = 1'b0;
   logic [rsws_pkg::StatW-1:0]     rsp_status;
   logic                           rsp_found;
   logic [rsws_pkg::CntW-1:0]      rsp_position;
   logic [rsws_pkg::CntW-1:0]      rsp_match_count;
   logic [rsws_pkg::IdW-1:0]       rsp_top_id;
   logic [rsws_pkg::DimW-1:0]      rsp_top_width;
   logic [rsws_pkg::DimW-1:0]      rsp_top_height;
   logic [rsws_pkg::KindW-1:0]     rsp_top_kind;
   logic [rsws_pkg::CntW-1:0]      rsp_fill_now;

   record_stack_with_search_top #(
      .DEPTH(DEPTH)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_key_mode    (req_key_mode),
      .req_rec_id      (req_rec_id),
      .req_rec_width   (req_rec_width),
      .req_rec_height  (req_rec_height),
      .req_rec_kind    (req_rec_kind),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position),
      .rsp_match_count (rsp_match_count),
      .rsp_top_id      (rsp_top_id),
      .rsp_top_width   (rsp_top_width),
      .rsp_top_height  (rsp_top_height),
      .rsp_top_kind    (rsp_top_kind),
      .rsp_fill_now    (rsp_fill_now)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   req_item_type  req_backlog[$];
   stack_rsp_type rsp_expected[$];
   req_item_type  sent_item;
   stack_rsp_type rsp_want;
   idle_mode_type idle_mode = IDLE_NONE;

   // shadow copy of the stack
   rsws_pkg::rec_type stack_mem [DEPTH];
   int                stack_fill = 0;

   int err_cnt    = 0;
   int n_sent     = 0;
   int n_recv     = 0;
   int n_full     = 0;
   int n_empty    = 0;
   int n_search   = 0;
   int n_hits     = 0;
   int peak_fill  = 0;
   int cycle_cnt  = 0;
   int hold_left  = 0;
   logic hold_done = 1'b0;

   function automatic logic key_hit(rsws_pkg::rec_type e, req_item_type it);
      logic hit;
      case (it.mode)
         rsws_pkg::KEY_ID:   hit = (e.id == it.rec.id);
         rsws_pkg::KEY_RES:  hit = (e.width == it.rec.width) &&
                                   (e.height == it.rec.height);
         rsws_pkg::KEY_KIND: hit = (e.kind == it.rec.kind);
         default:            hit = 1'b0;
      endcase
      return hit;
   endfunction

   function automatic stack_rsp_type stack_apply(req_item_type it);
      stack_rsp_type r;
      int hits;
      r = '0;
      hits = 0;
      case (it.op)
         rsws_pkg::OP_PUSH: begin
            if (stack_fill >= DEPTH) begin
               r.status = rsws_pkg::STAT_FULL;
               n_full++;
            end else begin
               stack_mem[stack_fill] = it.rec;
               stack_fill++;
            end
         end
         rsws_pkg::OP_POP: begin
            if (stack_fill == 0) begin
               r.status = rsws_pkg::STAT_EMPTY;
               n_empty++;
            end else begin
               stack_fill--;
            end
         end
         rsws_pkg::OP_PEEK: begin
            if (stack_fill == 0) begin
               r.status = rsws_pkg::STAT_EMPTY;
               n_empty++;
            end else begin
               r.top = stack_mem[stack_fill - 1];
            end
         end
         rsws_pkg::OP_CLEAR: stack_fill = 0;
         rsws_pkg::OP_FIND: begin
            // walk down from the top, stop at the first hit
            for (int i = stack_fill - 1; i >= 0 && !r.found; i--) begin
               if (key_hit(stack_mem[i], it)) begin
                  r.found    = 1'b1;
                  r.position = rsws_pkg::cnt_type'(stack_fill - i);
               end
            end
         end
         rsws_pkg::OP_COUNT: begin
            for (int i = 0; i < stack_fill; i++) begin
               if (key_hit(stack_mem[i], it)) hits++;
            end
            r.match_count = rsws_pkg::cnt_type'(hits);
            r.found       = (hits != 0);
         end
         default: ;
      endcase
      if (it.op == rsws_pkg::OP_FIND || it.op == rsws_pkg::OP_COUNT) begin
         n_search++;
         if (r.found) n_hits++;
      end
      if (stack_fill > peak_fill) peak_fill = stack_fill;
      r.fill_now = rsws_pkg::cnt_type'(stack_fill);
      return r;
   endfunction

   function automatic logic send_idle();
      case (idle_mode)
         IDLE_SEND: return $urandom_range(99) < 88;
         IDLE_BOTH: return $urandom_range(99) < 19;
         default:   return 1'b0;
      endcase
   endfunction

   function automatic logic rsp_stall();
      case (idle_mode)
         IDLE_RECV: return $urandom_range(99) < 88;
         IDLE_BOTH: return $urandom_range(99) < 19;
         default:   return 1'b0;
      endcase
   endfunction

   // driver: hold the transaction until taken, then predict and advance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            rsp_expected.push_back(stack_apply(sent_item));
            n_sent <= n_sent + 1;
         end
         if (!req_valid || req_ready) begin
            if (req_backlog.size() != 0 && !send_idle()) begin
               sent_item = req_backlog.pop_front();
               req_op         <= sent_item.op;
               req_key_mode   <= sent_item.mode;
               req_rec_id     <= sent_item.rec.id;
               req_rec_width  <= sent_item.rec.width;
               req_rec_height <= sent_item.rec.height;
               req_rec_kind   <= sent_item.rec.kind;
               req_valid      <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // one long receiver hold-off so the block backs up into its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_done && n_sent >= HOLD_AT) begin
         hold_left <= HOLD_LEN;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor: compare each result with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_recv <= n_recv + 1;
            if (rsp_expected.size() == 0) begin
               $display("%0t: unexpected result: status %0d fill_now %0d",
                        $time, rsp_status, rsp_fill_now);
               err_cnt++;
            end else begin
               rsp_want = rsp_expected.pop_front();
               if (rsp_status !== rsp_want.status) begin
                  $display("%0t: status expected %0d got %0d",
                           $time, rsp_want.status, rsp_status);
                  err_cnt++;
               end
               if (rsp_found !== rsp_want.found) begin
                  $display("%0t: found expected %0d got %0d",
                           $time, rsp_want.found, rsp_found);
                  err_cnt++;
               end
               if (rsp_position !== rsp_want.position) begin
                  $display("%0t: position expected %0d got %0d",
                           $time, rsp_want.position, rsp_position);
                  err_cnt++;
               end
               if (rsp_match_count !== rsp_want.match_count) begin
                  $display("%0t: match_count expected %0d got %0d",
                           $time, rsp_want.match_count, rsp_match_count);
                  err_cnt++;
               end
               if (rsp_top_id !== rsp_want.top.id) begin
                  $display("%0t: top_id expected %h got %h",
                           $time, rsp_want.top.id, rsp_top_id);
                  err_cnt++;
               end
               if (rsp_top_width !== rsp_want.top.width) begin
                  $display("%0t: top_width expected %h got %h",
                           $time, rsp_want.top.width, rsp_top_width);
                  err_cnt++;
               end
               if (rsp_top_height !== rsp_want.top.height) begin
                  $display("%0t: top_height expected %h got %h",
                           $time, rsp_want.top.height, rsp_top_height);
                  err_cnt++;
               end
               if (rsp_top_kind !== rsp_want.top.kind) begin
                  $display("%0t: top_kind expected %0d got %0d",
                           $time, rsp_want.top.kind, rsp_top_kind);
                  err_cnt++;
               end
               if (rsp_fill_now !== rsp_want.fill_now) begin
                  $display("%0t: fill_now expected %0d got %0d",
                           $time, rsp_want.fill_now, rsp_fill_now);
                  err_cnt++;
               end
            end
         end
         rsp_ready <= (hold_left == 0) && !rsp_stall();
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d results outstanding",
                  $time, cycle_cnt, rsp_expected.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic rsws_pkg::rec_type mk_rec(id_type id, dim_type w,
                                                dim_type h, kind_type k);
      rsws_pkg::rec_type x;
      x.id     = id;
      x.width  = w;
      x.height = h;
      x.kind   = k;
      return x;
   endfunction

   // small value pools half the time so that searches find something
   function automatic rsws_pkg::rec_type rand_rec();
      rsws_pkg::rec_type x;
      x.id     = $urandom_range(1) ? id_type'($urandom_range(7)) : id_type'($urandom);
      x.width  = $urandom_range(1) ? dim_type'($urandom_range(3))
                                   : dim_type'($urandom_range(8191));
      x.height = $urandom_range(1) ? dim_type'($urandom_range(3))
                                   : dim_type'($urandom_range(8191));
      x.kind   = kind_type'($urandom_range(7));
      return x;
   endfunction

   task automatic queue_item(input rsws_pkg::op_code_type op, input rsws_pkg::mode_type mode,
                             input rsws_pkg::rec_type rec);
      req_item_type it;
      it.op   = op;
      it.mode = mode;
      it.rec  = rec;
      req_backlog.push_back(it);
   endtask

   // bursts that fill, drain, mix, or fill with one repeated record
   task automatic gen_random(input int n);
      int left, burst, style, push_pct, pop_pct, r;
      rsws_pkg::rec_type fixed_rec, rec;
      rsws_pkg::op_code_type op;
      rsws_pkg::mode_type mode;
      left = n;
      while (left > 0) begin
         burst     = $urandom_range(150, 50);
         style     = $urandom_range(3);
         fixed_rec = rand_rec();
         case (style)
            0:       begin push_pct = 60; pop_pct = 8;  end
            1:       begin push_pct = 10; pop_pct = 50; end
            2:       begin push_pct = 30; pop_pct = 25; end
            default: begin push_pct = 70; pop_pct = 5;  end
         endcase
         for (int k = 0; k < burst && left > 0; k++) begin
            r = $urandom_range(99);
            if (r < push_pct) begin
               op = rsws_pkg::OP_PUSH;
            end else if (r < push_pct + pop_pct) begin
               op = rsws_pkg::OP_POP;
            end else begin
               r = $urandom_range(99);
               if (r < 2)       op = rsws_pkg::OP_CLEAR;
               else if (r < 6)  op = (r % 2) ? OP_BAD7 : OP_BAD6;
               else if (r < 30) op = rsws_pkg::OP_PEEK;
               else if (r < 65) op = rsws_pkg::OP_FIND;
               else             op = rsws_pkg::OP_COUNT;
            end
            mode = ($urandom_range(99) < 8) ? KEY_NONE
                                            : rsws_pkg::mode_type'($urandom_range(2));
            rec  = (style == 3 && (op == rsws_pkg::OP_PUSH || $urandom_range(1))) ?
                   fixed_rec : rand_rec();
            queue_item(op, mode, rec);
            left--;
         end
      end
   endtask

   task automatic wait_drained();
      while (req_backlog.size() != 0 || req_valid || rsp_expected.size() != 0)
         @(negedge clock);
   endtask

   task automatic run_phase(input idle_mode_type mode, input int n);
      idle_mode = mode;
      gen_random(n);
      wait_drained();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      idle_mode = IDLE_NONE;
      queue_item(rsws_pkg::OP_POP, rsws_pkg::KEY_ID,
                 mk_rec(16'h0000, 13'h0000, 13'h0000, 3'd0));
      queue_item(rsws_pkg::OP_PEEK, rsws_pkg::KEY_RES,
                 mk_rec(16'hFFFF, 13'h1FFF, 13'h1FFF, 3'd7));
      queue_item(rsws_pkg::OP_FIND, rsws_pkg::KEY_ID,
                 mk_rec(16'h0000, 13'h0000, 13'h0000, 3'd0));
      queue_item(rsws_pkg::OP_COUNT, rsws_pkg::KEY_KIND,
                 mk_rec(16'h0000, 13'h0000, 13'h0000, 3'd0));
      queue_item(rsws_pkg::OP_PUSH, rsws_pkg::KEY_ID,
                 mk_rec(16'hFFFF, 13'h1FFF, 13'h1FFF, 3'd7));
      queue_item(rsws_pkg::OP_PEEK, rsws_pkg::KEY_ID,
                 mk_rec(16'h0000, 13'h0000, 13'h0000, 3'd0));
      queue_item(rsws_pkg::OP_PUSH, rsws_pkg::KEY_ID,
                 mk_rec(16'h0000, 13'h0000, 13'h0000, 3'd0));
      queue_item(rsws_pkg::OP_PUSH, rsws_pkg::KEY_ID,
                 mk_rec(16'h0005, 13'h1FFF, 13'h0000, 3'd4));
      queue_item(rsws_pkg::OP_FIND, rsws_pkg::KEY_ID,
                 mk_rec(16'hFFFF, 13'h0000, 13'h0000, 3'd0));
      queue_item(rsws_pkg::OP_FIND, rsws_pkg::KEY_RES,
                 mk_rec(16'h0000, 13'h1FFF, 13'h0000, 3'd0));
      queue_item(rsws_pkg::OP_FIND, rsws_pkg::KEY_KIND,
                 mk_rec(16'h0000, 13'h0000, 13'h0000, 3'd7));
      queue_item(rsws_pkg::OP_COUNT, rsws_pkg::KEY_RES,
                 mk_rec(16'h0000, 13'h0000, 13'h0000, 3'd0));
      queue_item(rsws_pkg::OP_FIND, KEY_NONE,
                 mk_rec(16'h0000, 13'h0000, 13'h0000, 3'd0));
      queue_item(rsws_pkg::OP_COUNT, KEY_NONE,
                 mk_rec(16'h0000, 13'h0000, 13'h0000, 3'd0));
      queue_item(OP_BAD6, KEY_NONE,
                 mk_rec(16'hFFFF, 13'h1FFF, 13'h1FFF, 3'd7));
      queue_item(OP_BAD7, rsws_pkg::KEY_KIND,
                 mk_rec(16'h0000, 13'h0000, 13'h0000, 3'd0));
      queue_item(rsws_pkg::OP_FIND, rsws_pkg::KEY_ID,
                 mk_rec(16'h1234, 13'h0000, 13'h0000, 3'd0));
      queue_item(rsws_pkg::OP_POP, rsws_pkg::KEY_ID,
                 mk_rec(16'h0000, 13'h0000, 13'h0000, 3'd0));
      queue_item(rsws_pkg::OP_PEEK, rsws_pkg::KEY_ID,
                 mk_rec(16'h0000, 13'h0000, 13'h0000, 3'd0));
      queue_item(rsws_pkg::OP_CLEAR, rsws_pkg::KEY_ID,
                 mk_rec(16'hFFFF, 13'h1FFF, 13'h1FFF, 3'd7));
      queue_item(rsws_pkg::OP_PEEK, rsws_pkg::KEY_ID,
                 mk_rec(16'h0000, 13'h0000, 13'h0000, 3'd0));
      queue_item(rsws_pkg::OP_PUSH, rsws_pkg::KEY_ID,
                 mk_rec(16'h0009, 13'd100, 13'd200, 3'd5));
      queue_item(rsws_pkg::OP_COUNT, rsws_pkg::KEY_KIND,
                 mk_rec(16'h0000, 13'h0000, 13'h0000, 3'd5));
      queue_item(rsws_pkg::OP_FIND, rsws_pkg::KEY_ID,
                 mk_rec(16'h0009, 13'h0000, 13'h0000, 3'd0));
      wait_drained();

      run_phase(IDLE_NONE, 250);
      run_phase(IDLE_SEND, 150);
      run_phase(IDLE_RECV, 150);
      run_phase(IDLE_BOTH, 250);
      run_phase(IDLE_NONE, 100);

      // catch any stray result after the last expected one
      repeat (DRAIN_WAIT) @(negedge clock);

      $display("covered %0d transactions, %0d results, peak depth %0d of %0d",
               n_sent, n_recv, peak_fill, DEPTH);
      $display("searches %0d (%0d with a match), pushes on full %0d, pop/peek on empty %0d",
               n_search, n_hits, n_full, n_empty);
      if (err_cnt == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire
